// ===== hdl/bsr_pkg.sv =====
package bsr_pkg;

    localparam int CAPACITY   = 16;
    localparam int ITEM_WIDTH = 32;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int REQ_W      = 2;
    localparam int VALUE_W    = 32;
    localparam int OUT_CNT_W  = 5;

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_COUNT  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic scan_en;
        logic swap_rd;
        logic swap_wr;
        logic load_result;
    } cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic scan_done;
        logic is_clear;
        logic do_swap;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/bsr_ctrl.sv =====
module bsr_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  bsr_pkg::status_t status,
    output bsr_pkg::cmd_t   cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_SWAP_RD = 3'd2;
    localparam logic [2:0] S_SWAP_WR = 3'd3;
    localparam logic [2:0] S_RESULT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_en = !status.is_clear;
                if (status.is_clear || status.scan_done)
                begin
                    state_next = status.do_swap ? S_SWAP_RD : S_RESULT;
                end
            end
            S_SWAP_RD:
            begin
                cmd.swap_rd = 1'b1;
                state_next  = S_SWAP_WR;
            end
            S_SWAP_WR:
            begin
                cmd.swap_wr = 1'b1;
                state_next  = S_RESULT;
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/bsr_dp.sv =====
module bsr_dp
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  bsr_pkg::cmd_t                      cmd,
    output bsr_pkg::status_t                   status,
    input  logic [bsr_pkg::REQ_W-1:0]          req_type,
    input  logic [bsr_pkg::VALUE_W-1:0]        item_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               accepted,
    output logic                               full_reject,
    output logic [bsr_pkg::OUT_CNT_W-1:0]      match_count,
    output logic                               present,
    output logic [bsr_pkg::OUT_CNT_W-1:0]      size_now,
    output logic                               is_empty
);

    logic [bsr_pkg::ITEM_WIDTH-1:0] mem [bsr_pkg::CAPACITY];
    logic [bsr_pkg::ITEM_WIDTH-1:0] rdata_reg;

    logic [bsr_pkg::REQ_W-1:0]      req_reg;
    logic [bsr_pkg::ITEM_WIDTH-1:0] value_reg;
    logic [bsr_pkg::CNT_W-1:0]      count_reg;
    logic [bsr_pkg::CNT_W-1:0]      count_next;
    logic [bsr_pkg::CNT_W-1:0]      ptr_reg;
    logic [bsr_pkg::CNT_W-1:0]      ptr_next;
    logic [bsr_pkg::CNT_W-1:0]      match_reg;
    logic [bsr_pkg::CNT_W-1:0]      match_next;
    logic                           found_reg;
    logic                           found_next;
    logic [bsr_pkg::IDX_W-1:0]      found_idx_reg;
    logic [bsr_pkg::IDX_W-1:0]      found_idx_next;
    logic                           cmp_valid_reg;
    logic [bsr_pkg::IDX_W-1:0]      cmp_idx_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;

    logic                           scan_issue;
    logic                           hit;
    logic                           is_add;
    logic                           is_remove;
    logic                           is_count;
    logic                           is_clear;
    logic                           full;
    logic                           add_ok;
    logic [bsr_pkg::CNT_W-1:0]      last_cnt;
    logic [bsr_pkg::CNT_W-1:0]      size_after;
    logic                           rd_en;
    logic [bsr_pkg::IDX_W-1:0]      rd_addr;
    logic                           wr_en;
    logic [bsr_pkg::IDX_W-1:0]      wr_addr;
    logic [bsr_pkg::ITEM_WIDTH-1:0] wr_data;

    assign is_add    = (req_reg == bsr_pkg::REQ_ADD);
    assign is_remove = (req_reg == bsr_pkg::REQ_REMOVE);
    assign is_count  = (req_reg == bsr_pkg::REQ_COUNT);
    assign is_clear  = (req_reg == bsr_pkg::REQ_CLEAR);
    assign full      = (count_reg == bsr_pkg::CNT_W'(bsr_pkg::CAPACITY));
    assign add_ok    = is_add && !full;
    assign last_cnt  = count_reg - bsr_pkg::CNT_W'(1);

    // One entry is read per scan cycle; it is compared the cycle after.
    assign scan_issue = cmd.scan_en && (ptr_reg != count_reg);
    assign hit        = cmp_valid_reg && (rdata_reg == value_reg);

    assign rd_en   = scan_issue || cmd.swap_rd;
    assign rd_addr = cmd.swap_rd ? last_cnt[bsr_pkg::IDX_W-1:0]
                                 : ptr_reg[bsr_pkg::IDX_W-1:0];

    // The swap moves the last entry into the hole; an add appends at the count.
    assign wr_en   = cmd.swap_wr || (cmd.load_result && add_ok);
    assign wr_addr = cmd.swap_wr ? found_idx_reg : count_reg[bsr_pkg::IDX_W-1:0];
    assign wr_data = cmd.swap_wr ? rdata_reg : value_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        if (is_clear)
        begin
            size_after = '0;
        end
        else if (add_ok)
        begin
            size_after = count_reg + bsr_pkg::CNT_W'(1);
        end
        else
        begin
            size_after = count_reg;
        end
    end

    always_comb
    begin
        ptr_next       = ptr_reg;
        match_next     = match_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        count_next     = count_reg;
        if (cmd.accept)
        begin
            ptr_next   = '0;
            match_next = '0;
            found_next = 1'b0;
        end
        else
        begin
            if (scan_issue)
            begin
                ptr_next = ptr_reg + bsr_pkg::CNT_W'(1);
            end
            if (hit)
            begin
                match_next = match_reg + bsr_pkg::CNT_W'(1);
                if (!found_reg)
                begin
                    found_next     = 1'b1;
                    found_idx_next = cmp_idx_reg;
                end
            end
        end
        if (cmd.swap_wr)
        begin
            count_next = last_cnt;
        end
        else if (cmd.load_result)
        begin
            count_next = size_after;
        end
    end

    assign out_valid_next = cmd.load_result ? 1'b1
                          : (out_valid_reg && !out_stall) ? 1'b0 : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            match_reg     <= '0;
            found_reg     <= 1'b0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            req_reg       <= bsr_pkg::REQ_ADD;
        end
        else
        begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            match_reg     <= match_next;
            found_reg     <= found_next;
            cmp_valid_reg <= scan_issue;
            out_valid_reg <= out_valid_next;
            if (cmd.accept)
            begin
                req_reg <= req_type;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        found_idx_reg <= found_idx_next;
        cmp_idx_reg   <= ptr_reg[bsr_pkg::IDX_W-1:0];
        if (cmd.accept)
        begin
            value_reg <= bsr_pkg::ITEM_WIDTH'(item_value);
        end
        if (cmd.load_result)
        begin
            accepted    <= is_add ? !full : (is_remove ? found_reg : 1'b1);
            full_reject <= is_add && full;
            match_count <= is_count ? bsr_pkg::OUT_CNT_W'(match_reg) : '0;
            present     <= !is_clear && found_reg;
            size_now    <= bsr_pkg::OUT_CNT_W'(size_after);
            is_empty    <= (size_after == '0);
        end
    end

    assign out_valid = out_valid_reg;

    assign status.scan_done = (ptr_reg == count_reg) && !cmp_valid_reg;
    assign status.is_clear  = is_clear;
    assign status.do_swap   = is_remove && found_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

endmodule

// ===== hdl/bag_store_with_swap_remove_unit.sv =====
// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall  req_type, item_value
// result    out        out_valid / out_stall accepted, full_reject, match_count,
//                                            present, size_now, is_empty
//
// After an item is taken, each stored entry is read and compared (none for an empty
// store or a clear); a remove that finds its value then moves the last entry into the
// hole; then the result is loaded, and the next item can be taken in the cycle after.
// The entry memory's single read port sets the scan at one entry per cycle. Reset clears
// the entry count and control state, not the stored entries. While a result waits under
// out_stall the next item is still taken and scanned, its result held until the output frees.
module bag_store_with_swap_remove_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bsr_pkg::REQ_W-1:0]     req_type,
    input  logic [bsr_pkg::VALUE_W-1:0]   item_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          accepted,
    output logic                          full_reject,
    output logic [bsr_pkg::OUT_CNT_W-1:0] match_count,
    output logic                          present,
    output logic [bsr_pkg::OUT_CNT_W-1:0] size_now,
    output logic                          is_empty
);

    bsr_pkg::cmd_t    cmd;
    bsr_pkg::status_t status;

    bsr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    bsr_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .req_type    (req_type),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .accepted    (accepted),
        .full_reject (full_reject),
        .match_count (match_count),
        .present     (present),
        .size_now    (size_now),
        .is_empty    (is_empty)
    );

endmodule
